// ===== src/pms_pkg.sv =====
// Shared types, codes and widths of the place move sequencer.
package pms_pkg;

  localparam int PMS_POS_WIDTH  = 20;
  localparam int PMS_WAIT_WIDTH = 32;
  localparam int ANG_WIDTH      = 17;
  localparam int ERR_WIDTH      = 4;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CFG_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_REPLY  = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_IDLE  = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_DONE  = 2'd2,
    STAT_ERROR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PROF_DEFAULT = 2'd0,
    PROF_Z_DOWN  = 2'd1,
    PROF_Z_UP    = 2'd2
  } profile_t;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_RAISE         = 4'd1,
    PH_XY_MOVE       = 4'd2,
    PH_XY_SETTLE     = 4'd3,
    PH_Z_DOWN        = 4'd4,
    PH_Z_DOWN_SETTLE = 4'd5,
    PH_RELEASE_WAIT  = 4'd6,
    PH_Z_UP          = 4'd7,
    PH_Z_UP_SETTLE   = 4'd8,
    PH_DONE          = 4'd9,
    PH_ERROR         = 4'd10
  } phase_t;

  localparam logic [ERR_WIDTH-1:0] ERRC_CLEAR       = 4'd0;
  localparam logic [ERR_WIDTH-1:0] ERRC_NOT_RUNNING = 4'd15;

  localparam logic [REG_IDX_WIDTH-1:0] REG_SAFE_HEIGHT     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_DROP_HEIGHT     = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_XY_SETTLE_TICKS = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_Z_SETTLE_TICKS  = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_RELEASE_TICKS   = 3'd4;

endpackage

// ===== src/pms_in_if.sv =====
// Input channel of the place move sequencer: valid/ready with the command item.
interface pms_in_if #(
  parameter int POS_WIDTH = pms_pkg::PMS_POS_WIDTH
);
  import pms_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic signed [POS_WIDTH-1:0] goal_x;
  logic signed [POS_WIDTH-1:0] goal_y;
  logic signed [ANG_WIDTH-1:0] goal_angle;
  logic signed [POS_WIDTH-1:0] present_z;
  logic [ERR_WIDTH-1:0]        motion_error;

  modport source (
    output valid, cmd, goal_x, goal_y, goal_angle, present_z, motion_error,
    input  ready
  );

  modport sink (
    input  valid, cmd, goal_x, goal_y, goal_angle, present_z, motion_error,
    output ready
  );
endinterface

// ===== src/pms_out_if.sv =====
// Result channel of the place move sequencer: valid/ready with the result item.
interface pms_out_if #(
  parameter int POS_WIDTH = pms_pkg::PMS_POS_WIDTH
);
  import pms_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        finished;
  logic [ERR_WIDTH-1:0]        error_code;
  logic                        move_request;
  logic                        move_z_only;
  logic signed [POS_WIDTH-1:0] move_x;
  logic signed [POS_WIDTH-1:0] move_y;
  logic signed [POS_WIDTH-1:0] move_z;
  logic signed [ANG_WIDTH-1:0] move_angle;
  logic [1:0]                  move_profile;
  logic                        magnet_release;

  modport source (
    output valid, status, finished, error_code, move_request, move_z_only,
           move_x, move_y, move_z, move_angle, move_profile, magnet_release,
    input  ready
  );

  modport sink (
    input  valid, status, finished, error_code, move_request, move_z_only,
           move_x, move_y, move_z, move_angle, move_profile, magnet_release,
    output ready
  );
endinterface

// ===== src/pms_cfg_regs.sv =====
// APB-style configuration registers: heights and settle counts.
module pms_cfg_regs #(
  parameter int POS_WIDTH  = pms_pkg::PMS_POS_WIDTH,
  parameter int WAIT_WIDTH = pms_pkg::PMS_WAIT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pms_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [pms_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [pms_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output logic signed [POS_WIDTH-1:0]         safe_height,
  output logic signed [POS_WIDTH-1:0]         drop_height,
  output logic [WAIT_WIDTH-1:0]               xy_settle_ticks,
  output logic [WAIT_WIDTH-1:0]               z_settle_ticks,
  output logic [WAIT_WIDTH-1:0]               release_ticks
);
  import pms_pkg::*;

  logic signed [POS_WIDTH-1:0] safe_height_r;
  logic signed [POS_WIDTH-1:0] drop_height_r;
  logic [WAIT_WIDTH-1:0]       xy_settle_r;
  logic [WAIT_WIDTH-1:0]       z_settle_r;
  logic [WAIT_WIDTH-1:0]       release_r;
  logic                        wr_en;
  logic [REG_IDX_WIDTH-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      safe_height_r <= '0;
      drop_height_r <= '0;
      xy_settle_r   <= '0;
      z_settle_r    <= '0;
      release_r     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAFE_HEIGHT:     safe_height_r <= pwdata[POS_WIDTH-1:0];
        REG_DROP_HEIGHT:     drop_height_r <= pwdata[POS_WIDTH-1:0];
        REG_XY_SETTLE_TICKS: xy_settle_r   <= pwdata[WAIT_WIDTH-1:0];
        REG_Z_SETTLE_TICKS:  z_settle_r    <= pwdata[WAIT_WIDTH-1:0];
        REG_RELEASE_TICKS:   release_r     <= pwdata[WAIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAFE_HEIGHT:     prdata = CFG_DATA_WIDTH'(safe_height_r);
      REG_DROP_HEIGHT:     prdata = CFG_DATA_WIDTH'(drop_height_r);
      REG_XY_SETTLE_TICKS: prdata = CFG_DATA_WIDTH'(xy_settle_r);
      REG_Z_SETTLE_TICKS:  prdata = CFG_DATA_WIDTH'(z_settle_r);
      REG_RELEASE_TICKS:   prdata = CFG_DATA_WIDTH'(release_r);
      default:             prdata = '0;
    endcase
  end

  assign safe_height     = safe_height_r;
  assign drop_height     = drop_height_r;
  assign xy_settle_ticks = xy_settle_r;
  assign z_settle_ticks  = z_settle_r;
  assign release_ticks   = release_r;

endmodule

// ===== src/pms_seq_core.sv =====
// Sequencer state and the single-pass step logic that turns one item into one result.
module pms_seq_core #(
  parameter int POS_WIDTH  = pms_pkg::PMS_POS_WIDTH,
  parameter int WAIT_WIDTH = pms_pkg::PMS_WAIT_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  pms_pkg::cmd_t                        cmd,
  input  logic signed [POS_WIDTH-1:0]          goal_x,
  input  logic signed [POS_WIDTH-1:0]          goal_y,
  input  logic signed [pms_pkg::ANG_WIDTH-1:0] goal_angle,
  input  logic signed [POS_WIDTH-1:0]          present_z,
  input  logic [pms_pkg::ERR_WIDTH-1:0]        motion_error,
  input  logic signed [POS_WIDTH-1:0]          safe_height,
  input  logic signed [POS_WIDTH-1:0]          drop_height,
  input  logic [WAIT_WIDTH-1:0]                xy_settle_ticks,
  input  logic [WAIT_WIDTH-1:0]                z_settle_ticks,
  input  logic [WAIT_WIDTH-1:0]                release_ticks,
  output pms_pkg::status_t                     status,
  output logic                                 finished,
  output logic [pms_pkg::ERR_WIDTH-1:0]        error_code,
  output logic                                 move_request,
  output logic                                 move_z_only,
  output logic signed [POS_WIDTH-1:0]          move_x,
  output logic signed [POS_WIDTH-1:0]          move_y,
  output logic signed [POS_WIDTH-1:0]          move_z,
  output logic signed [pms_pkg::ANG_WIDTH-1:0] move_angle,
  output pms_pkg::profile_t                    move_profile,
  output logic                                 magnet_release
);
  import pms_pkg::*;

  phase_t                      phase_r, phase_nxt;
  logic                        awaiting_r, awaiting_nxt;
  logic [WAIT_WIDTH-1:0]       wait_r, wait_nxt;
  logic [ERR_WIDTH-1:0]        held_err_r, held_err_nxt;
  logic signed [POS_WIDTH-1:0] held_x_r, held_x_nxt;
  logic signed [POS_WIDTH-1:0] held_y_r, held_y_nxt;
  logic signed [ANG_WIDTH-1:0] held_ang_r, held_ang_nxt;

  logic                        move_phase;
  logic                        wait_phase;
  logic [WAIT_WIDTH-1:0]       limit;
  logic [WAIT_WIDTH-1:0]       wait_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      awaiting_r <= 1'b0;
      wait_r     <= '0;
      held_err_r <= ERRC_CLEAR;
      held_x_r   <= '0;
      held_y_r   <= '0;
      held_ang_r <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      awaiting_r <= awaiting_nxt;
      wait_r     <= wait_nxt;
      held_err_r <= held_err_nxt;
      held_x_r   <= held_x_nxt;
      held_y_r   <= held_y_nxt;
      held_ang_r <= held_ang_nxt;
    end
  end

  assign move_phase = (phase_r == PH_RAISE) || (phase_r == PH_XY_MOVE) ||
                      (phase_r == PH_Z_DOWN) || (phase_r == PH_Z_UP);

  always_comb begin
    wait_phase = 1'b1;
    unique case (phase_r)
      PH_XY_SETTLE:     limit = xy_settle_ticks;
      PH_Z_DOWN_SETTLE: limit = z_settle_ticks;
      PH_RELEASE_WAIT:  limit = release_ticks;
      PH_Z_UP_SETTLE:   limit = z_settle_ticks;
      default: begin
        limit      = '0;
        wait_phase = 1'b0;
      end
    endcase
  end

  // Saturate at the counter maximum
  assign wait_inc = (&wait_r) ? wait_r : wait_r + 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    awaiting_nxt   = awaiting_r;
    wait_nxt       = wait_r;
    held_err_nxt   = held_err_r;
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    held_ang_nxt   = held_ang_r;
    move_request   = 1'b0;
    move_z_only    = 1'b0;
    move_x         = '0;
    move_y         = '0;
    move_z         = '0;
    move_angle     = '0;
    move_profile   = PROF_DEFAULT;
    magnet_release = 1'b0;

    unique case (cmd)
      CMD_START: begin
        held_x_nxt   = goal_x;
        held_y_nxt   = goal_y;
        held_ang_nxt = goal_angle;
        held_err_nxt = ERRC_CLEAR;
        wait_nxt     = '0;
        awaiting_nxt = 1'b1;
        move_request = 1'b1;
        move_z       = safe_height;
        if (present_z > safe_height) begin
          move_z_only  = 1'b1;
          move_profile = PROF_Z_UP;
          phase_nxt    = PH_RAISE;
        end else begin
          move_x     = goal_x;
          move_y     = goal_y;
          move_angle = goal_angle;
          phase_nxt  = PH_XY_MOVE;
        end
      end
      CMD_REPLY: begin
        if (move_phase && awaiting_r) begin
          awaiting_nxt = 1'b0;
          if (motion_error != ERRC_CLEAR) begin
            phase_nxt    = PH_ERROR;
            held_err_nxt = motion_error;
          end
        end
      end
      CMD_FINISH: begin
        if (move_phase) begin
          awaiting_nxt = 1'b0;
          if (motion_error != ERRC_CLEAR) begin
            phase_nxt    = PH_ERROR;
            held_err_nxt = motion_error;
          end else if (phase_r == PH_RAISE) begin
            awaiting_nxt = 1'b1;
            move_request = 1'b1;
            move_x       = held_x_r;
            move_y       = held_y_r;
            move_z       = safe_height;
            move_angle   = held_ang_r;
            phase_nxt    = PH_XY_MOVE;
          end else begin
            wait_nxt = '0;
            if (phase_r == PH_XY_MOVE) begin
              phase_nxt = PH_XY_SETTLE;
            end else if (phase_r == PH_Z_DOWN) begin
              phase_nxt = PH_Z_DOWN_SETTLE;
            end else begin
              phase_nxt = PH_Z_UP_SETTLE;
            end
          end
        end
      end
      CMD_TICK: begin
        if (wait_phase) begin
          wait_nxt = wait_inc;
          if (wait_inc >= limit) begin
            priority case (phase_r)
              PH_XY_SETTLE: begin
                awaiting_nxt = 1'b1;
                move_request = 1'b1;
                move_z_only  = 1'b1;
                move_z       = drop_height;
                move_profile = PROF_Z_DOWN;
                phase_nxt    = PH_Z_DOWN;
              end
              PH_Z_DOWN_SETTLE: begin
                magnet_release = 1'b1;
                wait_nxt       = '0;
                phase_nxt      = PH_RELEASE_WAIT;
              end
              PH_RELEASE_WAIT: begin
                awaiting_nxt = 1'b1;
                move_request = 1'b1;
                move_z_only  = 1'b1;
                move_z       = safe_height;
                move_profile = PROF_Z_UP;
                phase_nxt    = PH_Z_UP;
              end
              default: begin
                phase_nxt    = PH_DONE;
                held_err_nxt = ERRC_CLEAR;
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (phase_nxt)
      PH_IDLE: begin
        status     = STAT_IDLE;
        finished   = 1'b1;
        error_code = ERRC_NOT_RUNNING;
      end
      PH_DONE: begin
        status     = STAT_DONE;
        finished   = 1'b1;
        error_code = ERRC_CLEAR;
      end
      PH_ERROR: begin
        status     = STAT_ERROR;
        finished   = 1'b1;
        error_code = held_err_nxt;
      end
      default: begin
        status     = STAT_BUSY;
        finished   = 1'b0;
        error_code = ERRC_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/place_move_sequencer_core.sv =====
// Place move sequencer: input register, sequencer step logic, result register.
// An accepted item waits in the input register until the result register is free or being drained.
// Throughput: one item per cycle while results are taken; the sequencer step is one pass of logic
// between the input register and the result register.
// Reset (rst_n low, synchronous): phase idle, both stages empty, configuration and held registers 0.
// Input is taken while a result waits, as long as the input register drains.
module place_move_sequencer_core #(
  parameter int POS_WIDTH  = pms_pkg::PMS_POS_WIDTH,
  parameter int WAIT_WIDTH = pms_pkg::PMS_WAIT_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pms_in_if.sink                             in_ch,
  pms_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pms_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [pms_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [pms_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import pms_pkg::*;

  logic signed [POS_WIDTH-1:0] safe_height;
  logic signed [POS_WIDTH-1:0] drop_height;
  logic [WAIT_WIDTH-1:0]       xy_settle_ticks;
  logic [WAIT_WIDTH-1:0]       z_settle_ticks;
  logic [WAIT_WIDTH-1:0]       release_ticks;

  // Input stage
  logic                        s1_valid_r, s1_valid_nxt;
  cmd_t                        s1_cmd_r;
  logic signed [POS_WIDTH-1:0] s1_goal_x_r;
  logic signed [POS_WIDTH-1:0] s1_goal_y_r;
  logic signed [ANG_WIDTH-1:0] s1_goal_ang_r;
  logic signed [POS_WIDTH-1:0] s1_present_z_r;
  logic [ERR_WIDTH-1:0]        s1_merr_r;

  // Result stage
  logic                        out_valid_r, out_valid_nxt;
  status_t                     out_status_r;
  logic                        out_finished_r;
  logic [ERR_WIDTH-1:0]        out_err_r;
  logic                        out_req_r;
  logic                        out_zonly_r;
  logic signed [POS_WIDTH-1:0] out_x_r;
  logic signed [POS_WIDTH-1:0] out_y_r;
  logic signed [POS_WIDTH-1:0] out_z_r;
  logic signed [ANG_WIDTH-1:0] out_ang_r;
  profile_t                    out_prof_r;
  logic                        out_release_r;

  // Step results
  status_t                     st_status;
  logic                        st_finished;
  logic [ERR_WIDTH-1:0]        st_err;
  logic                        st_req;
  logic                        st_zonly;
  logic signed [POS_WIDTH-1:0] st_x;
  logic signed [POS_WIDTH-1:0] st_y;
  logic signed [POS_WIDTH-1:0] st_z;
  logic signed [ANG_WIDTH-1:0] st_ang;
  profile_t                    st_prof;
  logic                        st_release;

  logic fire;
  logic in_take;

  pms_cfg_regs #(
    .POS_WIDTH  (POS_WIDTH),
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .safe_height     (safe_height),
    .drop_height     (drop_height),
    .xy_settle_ticks (xy_settle_ticks),
    .z_settle_ticks  (z_settle_ticks),
    .release_ticks   (release_ticks)
  );

  // Advance the held item when the result register is free or being drained
  assign fire    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || fire;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r       <= cmd_t'(in_ch.cmd);
      s1_goal_x_r    <= in_ch.goal_x;
      s1_goal_y_r    <= in_ch.goal_y;
      s1_goal_ang_r  <= in_ch.goal_angle;
      s1_present_z_r <= in_ch.present_z;
      s1_merr_r      <= in_ch.motion_error;
    end
  end

  pms_seq_core #(
    .POS_WIDTH  (POS_WIDTH),
    .WAIT_WIDTH (WAIT_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .cmd             (s1_cmd_r),
    .goal_x          (s1_goal_x_r),
    .goal_y          (s1_goal_y_r),
    .goal_angle      (s1_goal_ang_r),
    .present_z       (s1_present_z_r),
    .motion_error    (s1_merr_r),
    .safe_height     (safe_height),
    .drop_height     (drop_height),
    .xy_settle_ticks (xy_settle_ticks),
    .z_settle_ticks  (z_settle_ticks),
    .release_ticks   (release_ticks),
    .status          (st_status),
    .finished        (st_finished),
    .error_code      (st_err),
    .move_request    (st_req),
    .move_z_only     (st_zonly),
    .move_x          (st_x),
    .move_y          (st_y),
    .move_z          (st_z),
    .move_angle      (st_ang),
    .move_profile    (st_prof),
    .magnet_release  (st_release)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r   <= st_status;
      out_finished_r <= st_finished;
      out_err_r      <= st_err;
      out_req_r      <= st_req;
      out_zonly_r    <= st_zonly;
      out_x_r        <= st_x;
      out_y_r        <= st_y;
      out_z_r        <= st_z;
      out_ang_r      <= st_ang;
      out_prof_r     <= st_prof;
      out_release_r  <= st_release;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.finished       = out_finished_r;
  assign out_ch.error_code     = out_err_r;
  assign out_ch.move_request   = out_req_r;
  assign out_ch.move_z_only    = out_zonly_r;
  assign out_ch.move_x         = out_x_r;
  assign out_ch.move_y         = out_y_r;
  assign out_ch.move_z         = out_z_r;
  assign out_ch.move_angle     = out_ang_r;
  assign out_ch.move_profile   = out_prof_r;
  assign out_ch.magnet_release = out_release_r;

`ifndef SYNTHESIS
  // A full input stage taking a new transaction must be handing its item on
  a_refill_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && s1_valid_r) |-> fire)
    else $error("input stage overwritten before its item advanced");

  // A motion request is only ever issued while the sequence is running
  a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_req_r) |-> (out_status_r == STAT_BUSY))
    else $error("move request outside a running sequence");

  // Finished flag tracks status
  a_finished_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_finished_r == (out_status_r != STAT_BUSY)))
    else $error("finished flag disagrees with status");

  // Magnet release never coincides with a move request
  a_release_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_release_r) |-> (!out_req_r && out_err_r == ERRC_CLEAR))
    else $error("magnet release combined with a request or an error");
`endif

endmodule

// ===== test/place_move_sequencer_core_test.sv =====
// Self-checking testbench of the place move sequencer: directed table, then random sequences.
`timescale 1ns / 1ps

module place_move_sequencer_core_test;
  import pms_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_MAX  = 10;

  localparam logic signed [PMS_POS_WIDTH-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [PMS_POS_WIDTH-1:0] POS_MIN = 20'sh80000;
  localparam logic signed [PMS_POS_WIDTH-1:0] POS_ONE = 20'sd1;
  localparam logic signed [PMS_POS_WIDTH-1:0] POS_NEG = -20'sd1;
  localparam logic signed [PMS_POS_WIDTH-1:0] POS_ZERO = 20'sd0;
  localparam logic signed [ANG_WIDTH-1:0]     ANG_MAX = 17'sh0FFFF;
  localparam logic signed [ANG_WIDTH-1:0]     ANG_MIN = 17'sh10000;
  localparam logic signed [ANG_WIDTH-1:0]     ANG_ZERO = 17'sd0;
  localparam logic [ERR_WIDTH-1:0] MERR_ANY  = 4'd5;
  localparam logic [ERR_WIDTH-1:0] MERR_MID  = 4'd3;
  localparam logic [ERR_WIDTH-1:0] MERR_LAST = 4'd14;
  localparam logic [ERR_WIDTH-1:0] MERR_TOP  = 4'd15;

  typedef struct packed {
    cmd_t                            cmd;
    logic signed [PMS_POS_WIDTH-1:0] goal_x;
    logic signed [PMS_POS_WIDTH-1:0] goal_y;
    logic signed [ANG_WIDTH-1:0]     goal_angle;
    logic signed [PMS_POS_WIDTH-1:0] present_z;
    logic [ERR_WIDTH-1:0]            motion_error;
  } place_item_t;

  typedef struct packed {
    logic [1:0]                      status;
    logic                            finished;
    logic [ERR_WIDTH-1:0]            error_code;
    logic                            move_request;
    logic                            move_z_only;
    logic signed [PMS_POS_WIDTH-1:0] move_x;
    logic signed [PMS_POS_WIDTH-1:0] move_y;
    logic signed [PMS_POS_WIDTH-1:0] move_z;
    logic signed [ANG_WIDTH-1:0]     move_angle;
    logic [1:0]                      move_profile;
    logic                            magnet_release;
  } place_result_t;

  typedef struct packed {
    place_item_t          item;
    logic                 typed;
    status_t              status;
    logic [ERR_WIDTH-1:0] error_code;
  } place_row_t;

  // status and error code are typed in only where they are obvious
  localparam place_row_t PLACE_ROWS [24] = '{
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_IDLE,
      ERRC_NOT_RUNNING},
    '{'{CMD_REPLY,  POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, MERR_ANY},   1'b1, STAT_IDLE,
      ERRC_NOT_RUNNING},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_IDLE,
      ERRC_NOT_RUNNING},
    '{'{CMD_START,  POS_MAX,  POS_MIN,  ANG_MAX,  POS_MAX,  ERRC_CLEAR}, 1'b1, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_REPLY,  POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_REPLY,  POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_REPLY,  POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, MERR_MID},   1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b0, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_DONE,  ERRC_CLEAR},
    '{'{CMD_TICK,   POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_DONE,  ERRC_CLEAR},
    '{'{CMD_START,  POS_MIN,  POS_MAX,  ANG_MIN,  POS_MIN,  ERRC_CLEAR}, 1'b1, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_REPLY,  POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, MERR_TOP},   1'b1, STAT_ERROR, MERR_TOP},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_ERROR, MERR_TOP},
    '{'{CMD_START,  POS_ONE,  POS_NEG,  ANG_MAX,  POS_ZERO, ERRC_CLEAR}, 1'b1, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_FINISH, POS_ZERO, POS_ZERO, ANG_ZERO, POS_ZERO, MERR_LAST},  1'b1, STAT_ERROR, MERR_LAST},
    '{'{CMD_START,  POS_NEG,  POS_ONE,  ANG_MIN,  POS_ONE,  ERRC_CLEAR}, 1'b1, STAT_BUSY,  ERRC_CLEAR},
    '{'{CMD_START,  POS_MAX,  POS_MAX,  ANG_ZERO, POS_NEG,  ERRC_CLEAR}, 1'b1, STAT_BUSY,  ERRC_CLEAR}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata, prdata;

  pms_in_if  in_ch ();
  pms_out_if out_ch ();

  place_move_sequencer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // sequencer state as the block should hold it
  logic signed [PMS_POS_WIDTH-1:0] cfg_safe = '0, cfg_drop = '0;
  logic [PMS_WAIT_WIDTH-1:0]       cfg_xy = '0, cfg_z = '0, cfg_rel = '0;
  phase_t                          seq_phase = PH_IDLE;
  logic                            awaiting = 1'b0;
  logic [PMS_WAIT_WIDTH-1:0]       wait_cnt = '0;
  logic [ERR_WIDTH-1:0]            held_err = '0;
  logic signed [PMS_POS_WIDTH-1:0] held_x = '0, held_y = '0;
  logic signed [ANG_WIDTH-1:0]     held_angle = '0;

  place_result_t awaited_results [$];
  int mismatches, items_sent, results_seen, cycles, settings_used;
  int placements, aborts, releases;
  bit quiet;

  function automatic void ask_z(inout place_result_t r,
                                input logic signed [PMS_POS_WIDTH-1:0] z, input profile_t prof);
    r.move_request = 1'b1;
    r.move_z_only  = 1'b1;
    r.move_z       = z;
    r.move_profile = prof;
    awaiting = 1'b1;
  endfunction

  function automatic void ask_xy(inout place_result_t r);
    r.move_request = 1'b1;
    r.move_z_only  = 1'b0;
    r.move_x       = held_x;
    r.move_y       = held_y;
    r.move_z       = cfg_safe;
    r.move_angle   = held_angle;
    r.move_profile = PROF_DEFAULT;
    awaiting  = 1'b1;
    seq_phase = PH_XY_MOVE;
  endfunction

  function automatic void abort_sequence(input logic [ERR_WIDTH-1:0] code);
    seq_phase = PH_ERROR;
    held_err  = code;
    awaiting  = 1'b0;
    aborts++;
  endfunction

  function automatic place_result_t sequence_step(input place_item_t it);
    place_result_t r;
    logic [PMS_WAIT_WIDTH-1:0] limit;
    bit in_move, in_wait;
    r = '0;
    limit = '0;
    in_wait = 1'b1;
    in_move = (seq_phase == PH_RAISE) || (seq_phase == PH_XY_MOVE) ||
              (seq_phase == PH_Z_DOWN) || (seq_phase == PH_Z_UP);
    case (it.cmd)
      CMD_START: begin
        held_x     = it.goal_x;
        held_y     = it.goal_y;
        held_angle = it.goal_angle;
        held_err   = ERRC_CLEAR;
        wait_cnt   = '0;
        awaiting   = 1'b0;
        if ($signed(it.present_z) > $signed(cfg_safe)) begin
          ask_z(r, cfg_safe, PROF_Z_UP);
          seq_phase = PH_RAISE;
        end else begin
          ask_xy(r);
        end
      end
      CMD_REPLY: begin
        if (in_move && awaiting) begin
          awaiting = 1'b0;
          if (it.motion_error != ERRC_CLEAR) abort_sequence(it.motion_error);
        end
      end
      CMD_FINISH: begin
        if (in_move) begin
          awaiting = 1'b0;
          wait_cnt = '0;
          if (it.motion_error != ERRC_CLEAR) abort_sequence(it.motion_error);
          else begin
            case (seq_phase)
              PH_RAISE:   ask_xy(r);
              PH_XY_MOVE: seq_phase = PH_XY_SETTLE;
              PH_Z_DOWN:  seq_phase = PH_Z_DOWN_SETTLE;
              default:    seq_phase = PH_Z_UP_SETTLE;
            endcase
          end
        end
      end
      default: begin
        case (seq_phase)
          PH_XY_SETTLE:                     limit = cfg_xy;
          PH_Z_DOWN_SETTLE, PH_Z_UP_SETTLE: limit = cfg_z;
          PH_RELEASE_WAIT:                  limit = cfg_rel;
          default:                          in_wait = 1'b0;
        endcase
        if (in_wait) begin
          if (wait_cnt != '1) wait_cnt++;
          if (wait_cnt >= limit) begin
            case (seq_phase)
              PH_XY_SETTLE: begin
                ask_z(r, cfg_drop, PROF_Z_DOWN);
                seq_phase = PH_Z_DOWN;
              end
              PH_Z_DOWN_SETTLE: begin
                r.magnet_release = 1'b1;
                releases++;
                seq_phase = PH_RELEASE_WAIT;
                wait_cnt = '0;
              end
              PH_RELEASE_WAIT: begin
                ask_z(r, cfg_safe, PROF_Z_UP);
                seq_phase = PH_Z_UP;
              end
              default: begin
                seq_phase = PH_DONE;
                held_err = ERRC_CLEAR;
                placements++;
              end
            endcase
          end
        end
      end
    endcase
    case (seq_phase)
      PH_IDLE: begin
        r.status = STAT_IDLE; r.finished = 1'b1; r.error_code = ERRC_NOT_RUNNING;
      end
      PH_DONE:  begin r.status = STAT_DONE;  r.finished = 1'b1; r.error_code = ERRC_CLEAR; end
      PH_ERROR: begin r.status = STAT_ERROR; r.finished = 1'b1; r.error_code = held_err; end
      default:  begin r.status = STAT_BUSY;  r.finished = 1'b0; r.error_code = ERRC_CLEAR; end
    endcase
    return r;
  endfunction

  function automatic string diff_fields(input place_result_t e, input place_result_t g);
    string s;
    s = "";
    if (g.status !== e.status)
      s = {s, $sformatf(" status %0d/%0d", e.status, g.status)};
    if (g.finished !== e.finished)
      s = {s, $sformatf(" finished %0d/%0d", e.finished, g.finished)};
    if (g.error_code !== e.error_code)
      s = {s, $sformatf(" error_code %0d/%0d", e.error_code, g.error_code)};
    if (g.move_request !== e.move_request)
      s = {s, $sformatf(" move_request %0d/%0d", e.move_request, g.move_request)};
    if (g.move_z_only !== e.move_z_only)
      s = {s, $sformatf(" move_z_only %0d/%0d", e.move_z_only, g.move_z_only)};
    if (g.move_x !== e.move_x)
      s = {s, $sformatf(" move_x %0d/%0d", $signed(e.move_x), $signed(g.move_x))};
    if (g.move_y !== e.move_y)
      s = {s, $sformatf(" move_y %0d/%0d", $signed(e.move_y), $signed(g.move_y))};
    if (g.move_z !== e.move_z)
      s = {s, $sformatf(" move_z %0d/%0d", $signed(e.move_z), $signed(g.move_z))};
    if (g.move_angle !== e.move_angle)
      s = {s, $sformatf(" move_angle %0d/%0d", $signed(e.move_angle), $signed(g.move_angle))};
    if (g.move_profile !== e.move_profile)
      s = {s, $sformatf(" move_profile %0d/%0d", e.move_profile, g.move_profile)};
    if (g.magnet_release !== e.magnet_release)
      s = {s, $sformatf(" magnet_release %0d/%0d", e.magnet_release, g.magnet_release)};
    return s;
  endfunction

  // steer towards well-formed sequences from the predicted phase, with some noise
  function automatic place_item_t pick_item();
    place_item_t it;
    int unsigned zsel;
    it.goal_x     = PMS_POS_WIDTH'($urandom);
    it.goal_y     = PMS_POS_WIDTH'($urandom);
    it.goal_angle = ANG_WIDTH'($urandom);
    zsel = $urandom_range(0, 5);
    case (zsel)
      0:       it.present_z = cfg_safe;
      1:       it.present_z = cfg_safe + POS_ONE;
      2:       it.present_z = cfg_safe - POS_ONE;
      default: it.present_z = PMS_POS_WIDTH'($urandom);
    endcase
    it.motion_error = ($urandom_range(0, 29) == 0) ? ERR_WIDTH'($urandom_range(1, 15)) :
                      ERRC_CLEAR;
    it.cmd = CMD_TICK;
    if ($urandom_range(0, 99) < 12) begin
      it.cmd = cmd_t'($urandom_range(0, 3));
      it.motion_error = ERR_WIDTH'($urandom);
    end else begin
      case (seq_phase)
        PH_IDLE, PH_DONE, PH_ERROR: it.cmd = CMD_START;
        PH_RAISE, PH_XY_MOVE, PH_Z_DOWN, PH_Z_UP:
          it.cmd = (awaiting && $urandom_range(0, 2) != 0) ? CMD_REPLY : CMD_FINISH;
        default: it.cmd = CMD_TICK;
      endcase
    end
    return it;
  endfunction

  // starts and returns at a falling edge; valid stays high for a following item
  task automatic offer(input place_item_t it, input logic typed, input status_t st,
                       input logic [ERR_WIDTH-1:0] err);
    place_result_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= it.cmd;
    in_ch.goal_x       <= it.goal_x;
    in_ch.goal_y       <= it.goal_y;
    in_ch.goal_angle   <= it.goal_angle;
    in_ch.present_z    <= it.present_z;
    in_ch.motion_error <= it.motion_error;
    do @(posedge clk); while (!in_ch.ready);
    r = sequence_step(it);
    if (typed) begin
      r.status     = st;
      r.finished   = (st != STAT_BUSY);
      r.error_code = err;
    end
    awaited_results.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SAFE_HEIGHT:     cfg_safe = val[PMS_POS_WIDTH-1:0];
      REG_DROP_HEIGHT:     cfg_drop = val[PMS_POS_WIDTH-1:0];
      REG_XY_SETTLE_TICKS: cfg_xy   = val;
      REG_Z_SETTLE_TICKS:  cfg_z    = val;
      default:             cfg_rel  = val;
    endcase
    @(negedge clk);
  endtask

  // drain the block, then load a full set of registers
  task automatic configure(input logic [31:0] safe, input logic [31:0] drop,
                           input logic [31:0] xy, input logic [31:0] zs, input logic [31:0] rel);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_SAFE_HEIGHT, safe);
    write_reg(REG_DROP_HEIGHT, drop);
    write_reg(REG_XY_SETTLE_TICKS, xy);
    write_reg(REG_Z_SETTLE_TICKS, zs);
    write_reg(REG_RELEASE_TICKS, rel);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) offer(pick_item(), 1'b0, STAT_IDLE, ERRC_CLEAR);
    in_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off to fill the block
  int  hold_left;
  bit  long_hold_done;
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && !long_hold_done && results_seen >= 120) begin
      long_hold_done = 1'b1;
      hold_left = 59;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  place_result_t got, oldest;
  string         diffs;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.status         = out_ch.status;
      got.finished       = out_ch.finished;
      got.error_code     = out_ch.error_code;
      got.move_request   = out_ch.move_request;
      got.move_z_only    = out_ch.move_z_only;
      got.move_x         = out_ch.move_x;
      got.move_y         = out_ch.move_y;
      got.move_z         = out_ch.move_z;
      got.move_angle     = out_ch.move_angle;
      got.move_profile   = out_ch.move_profile;
      got.magnet_release = out_ch.magnet_release;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result %0d arrived with nothing awaited", $realtime, results_seen);
      end else begin
        oldest = awaited_results.pop_front();
        diffs  = diff_fields(oldest, got);
        if (diffs != "") begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("[%0t] result %0d mismatch (expected/actual):%s",
                     $realtime, results_seen, diffs);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, awaited_results.size());
      $display("FAIL place_move_sequencer_core");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_TICK;
    in_ch.goal_x       = '0;
    in_ch.goal_y       = '0;
    in_ch.goal_angle   = '0;
    in_ch.present_z    = '0;
    in_ch.motion_error = '0;
    out_ch.ready       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part runs on the reset register values
    foreach (PLACE_ROWS[i])
      offer(PLACE_ROWS[i].item, PLACE_ROWS[i].typed, PLACE_ROWS[i].status,
            PLACE_ROWS[i].error_code);
    in_ch.valid <= 1'b0;

    // safe height at the top of the range, drop at the bottom, no settling
    configure(32'h0007FFFF, 32'h00080000, 32'd0, 32'd0, 32'd0);
    run_random(100);
    // safe height at the bottom, so nearly every start raises first
    configure(32'hFFF80000, 32'h0007FFFF, 32'd3, 32'd1, 32'd2);
    run_random(100);
    configure($urandom, $urandom, $urandom_range(0, 6), $urandom_range(0, 6),
              $urandom_range(0, 6));
    run_random(100);
    // xy settle that never ends; only a new start gets out of it
    configure($urandom, $urandom, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    run_random(40);
    quiet = 1'b1;
    configure($urandom_range(0, 1000), $urandom_range(0, 2000), $urandom_range(0, 2),
              $urandom_range(0, 2), $urandom_range(0, 2));
    run_random(110);

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d commands, checked %0d results over %0d register settings",
             items_sent, results_seen, settings_used);
    $display("Sequences: %0d placed, %0d aborted on error, %0d magnet releases",
             placements, aborts, releases);
    if (mismatches == 0) begin
      $display("PASS place_move_sequencer_core");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("FAIL place_move_sequencer_core");
    end
    $finish;
  end

endmodule

// ===== place_move_sequencer_core.f =====
src/pms_pkg.sv
src/pms_in_if.sv
src/pms_out_if.sv
src/pms_cfg_regs.sv
src/pms_seq_core.sv
src/place_move_sequencer_core.sv
test/place_move_sequencer_core_test.sv
